>>> rtl/gbd_pkg.sv
// Shared types and constants of the grid block decomposition.
package gbd_pkg;

    localparam int RANK_W  = 12;
    localparam int GRID_W  = 13;
    localparam int BOUND_W = 25;
    localparam int ADDR_W  = 4;

    localparam logic [2:0] MODE_SLAB   = 3'd1;
    localparam logic [2:0] MODE_PENCIL = 3'd2;
    localparam logic [2:0] MODE_CUBE   = 3'd3;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_ODD   = 2'd1;
    localparam logic [1:0] STAT_FATAL = 2'd2;

    localparam logic [1:0] REG_DIM_MODE   = 2'd0;
    localparam logic [1:0] REG_GRID_SIZE  = 2'd1;
    localparam logic [1:0] REG_PROC_COUNT = 2'd2;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_ROOT = 5'b00010,
        ST_MOD  = 5'b00100,
        ST_SQ   = 5'b01000,
        ST_USED = 5'b10000
    } t_seq_state;

endpackage

>>> rtl/gbd_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module gbd_div #(
    parameter int DW = 12,
    parameter int NW = 13,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_vld,
    input  logic [DW-1:0] i_num,
    input  logic [NW-1:0] i_den,
    input  logic [SW-1:0] i_side,
    output logic          o_vld,
    output logic [DW-1:0] o_quo,
    output logic [NW-1:0] o_rem,
    output logic [SW-1:0] o_side
);

    logic [NW-1:0] r_rem  [DW];
    logic [DW-1:0] r_q    [DW];
    logic [NW-1:0] r_den  [DW];
    logic [SW-1:0] r_side [DW];
    logic [DW-1:0] r_vld;

    for (genvar s = 0; s < DW; s++) begin : g_stage
        logic [NW-1:0] w_rem_in;
        logic [NW-1:0] w_den_in;
        logic [DW-1:0] w_q_in;
        logic [SW-1:0] w_side_in;
        logic          w_vld_in;
        logic [NW:0]   w_trial;
        logic [NW:0]   w_diff;
        logic          w_ge;

        if (s == 0) begin : g_first
            assign w_rem_in  = '0;
            assign w_den_in  = i_den;
            assign w_q_in    = i_num;
            assign w_side_in = i_side;
            assign w_vld_in  = i_vld;
        end else begin : g_next
            assign w_rem_in  = r_rem[s-1];
            assign w_den_in  = r_den[s-1];
            assign w_q_in    = r_q[s-1];
            assign w_side_in = r_side[s-1];
            assign w_vld_in  = r_vld[s-1];
        end

        // Shift in the next dividend bit and subtract when it fits.
        assign w_trial = {w_rem_in, w_q_in[DW-1]};
        assign w_diff  = w_trial - {1'b0, w_den_in};
        assign w_ge    = (w_trial >= {1'b0, w_den_in});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= w_vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= w_ge ? w_diff[NW-1:0] : w_trial[NW-1:0];
                r_q[s]    <= {w_q_in[DW-2:0], w_ge};
                r_den[s]  <= w_den_in;
                r_side[s] <= w_side_in;
            end
        end
    end

    assign o_vld  = r_vld[DW-1];
    assign o_quo  = r_q[DW-1];
    assign o_rem  = r_rem[DW-1];
    assign o_side = r_side[DW-1];

endmodule

>>> rtl/grid_block_decomposition_top.sv
// Top level of the grid block decomposition: register port, setup sequencer and datapath.
// An accepted rank beat passes through two 12-stage rank dividers, one multiply stage,
// a 25-stage bound divider and the output register before it leaves as a result beat.
// Throughput: one beat per cycle while o_stall is low; the bound dividers are fully pipelined.
// After reset and after every register write a setup pass derives the division count;
// no rank beat is taken during that pass.
// Reset is synchronous and active low and loads dim_mode 3, grid_size 256, proc_count 1.
module grid_block_decomposition_top
    import gbd_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // Register port.
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [ADDR_W-1:0]         paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    // Rank input channel.
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [RANK_W-1:0]         i_rank,
    // Result channel.
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic signed [BOUND_W-1:0] o_x_lo,
    output logic signed [BOUND_W-1:0] o_x_hi,
    output logic signed [BOUND_W-1:0] o_y_lo,
    output logic signed [BOUND_W-1:0] o_y_hi,
    output logic signed [BOUND_W-1:0] o_z_lo,
    output logic signed [BOUND_W-1:0] o_z_hi,
    output logic [RANK_W-1:0]         o_mirror_rank,
    output logic                      o_upper_half,
    output logic [GRID_W-1:0]         o_used_procs,
    output logic [1:0]                o_status
);

    // ------------------------------------------------------------------
    // Configuration registers. Writes land on the access phase.
    // ------------------------------------------------------------------
    logic [2:0]        r_dim_mode;
    logic [GRID_W-1:0] r_grid_size;
    logic [GRID_W-1:0] r_proc_count;
    logic              w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim_mode   <= MODE_CUBE;
            r_grid_size  <= GRID_W'(256);
            r_proc_count <= GRID_W'(1);
        end else if (w_wr) begin
            case (paddr[3:2])
                REG_DIM_MODE:   r_dim_mode   <= pwdata[2:0];
                REG_GRID_SIZE:  r_grid_size  <= pwdata[GRID_W-1:0];
                REG_PROC_COUNT: r_proc_count <= pwdata[GRID_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_DIM_MODE:   prdata = {29'd0, r_dim_mode};
            REG_GRID_SIZE:  prdata = {19'd0, r_grid_size};
            REG_PROC_COUNT: prdata = {19'd0, r_proc_count};
            default:        prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Setup sequencer. It finds the integer square or cube root of the
    // processor count by stepping a candidate and keeping running squares
    // and cubes up to date with adds only, checks that the grid divides
    // evenly for slabs with a serial restoring remainder, and then forms
    // the used processor count with two registered multiplies.
    // ------------------------------------------------------------------
    t_seq_state        r_state;
    logic [GRID_W-1:0] r_root;
    logic [14:0]       r_s1;      // (root+1)^2
    logic [14:0]       r_c1;      // (root+1)^3
    logic [GRID_W-1:0] r_mrem;
    logic [GRID_W-1:0] r_mnum;
    logic [3:0]        r_mcnt;
    logic [GRID_W-1:0] r_ndiv;
    logic              r_odd;
    logic [GRID_W-1:0] r_sq;
    logic [GRID_W-1:0] r_used;
    logic [1:0]        r_status;
    logic              r_fatal;
    logic              r_serial;

    logic              w_reg_hit;
    logic              w_root_ok;
    logic [GRID_W-1:0] w_root_final;
    logic [GRID_W:0]   w_mtrial;
    logic [GRID_W:0]   w_mdiff;
    logic [GRID_W-1:0] w_used_calc;
    logic              w_fatal_calc;

    assign w_reg_hit = w_wr && (paddr[3:2] == REG_DIM_MODE || paddr[3:2] == REG_GRID_SIZE
                                || paddr[3:2] == REG_PROC_COUNT);
    assign w_root_ok = (r_dim_mode == MODE_PENCIL) ? (r_s1 <= {2'b0, r_proc_count})
                                                   : (r_c1 <= {2'b0, r_proc_count});
    assign w_root_final = (r_dim_mode == MODE_SLAB) ? r_proc_count : r_root;
    assign w_mtrial = {r_mrem, r_mnum[GRID_W-1]};
    assign w_mdiff  = w_mtrial - {1'b0, r_proc_count};

    always_comb begin
        case (r_dim_mode)
            MODE_SLAB:   w_used_calc = r_ndiv;
            MODE_PENCIL: w_used_calc = r_sq;
            default:     w_used_calc = GRID_W'(r_sq * r_ndiv);
        endcase
    end

    always_comb begin
        w_fatal_calc = (r_proc_count == '0);
        case (r_dim_mode)
            MODE_SLAB:   if (r_mrem != '0) w_fatal_calc = 1'b1;
            MODE_PENCIL: if (w_used_calc < GRID_W'(4)) w_fatal_calc = 1'b1;
            MODE_CUBE:   if (w_used_calc < GRID_W'(8)) w_fatal_calc = 1'b1;
            default:     w_fatal_calc = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_reg_hit) begin
            r_state <= ST_ROOT;
            r_root  <= '0;
            r_s1    <= 15'd1;
            r_c1    <= 15'd1;
        end else begin
            case (r_state)
                ST_ROOT: begin
                    if ((r_dim_mode == MODE_PENCIL || r_dim_mode == MODE_CUBE) && w_root_ok) begin
                        r_root <= r_root + GRID_W'(1);
                        r_s1   <= r_s1 + 15'({r_root, 1'b0}) + 15'd3;
                        r_c1   <= r_c1 + 15'({r_s1, 1'b0}) + r_s1
                                  + 15'({r_root, 1'b0}) + 15'(r_root) + 15'd4;
                    end else begin
                        r_ndiv  <= {w_root_final[GRID_W-1:1], 1'b0};
                        r_odd   <= w_root_final[0];
                        r_mrem  <= '0;
                        r_mnum  <= r_grid_size;
                        r_mcnt  <= '0;
                        r_state <= ST_MOD;
                    end
                end
                ST_MOD: begin
                    r_mrem <= (w_mtrial >= {1'b0, r_proc_count}) ? w_mdiff[GRID_W-1:0]
                                                                  : w_mtrial[GRID_W-1:0];
                    r_mnum <= {r_mnum[GRID_W-2:0], 1'b0};
                    r_mcnt <= r_mcnt + 4'd1;
                    if (r_mcnt == 4'(GRID_W - 1)) begin
                        r_state <= ST_SQ;
                    end
                end
                ST_SQ: begin
                    r_sq    <= GRID_W'(r_ndiv * r_ndiv);
                    r_state <= ST_USED;
                end
                ST_USED: begin
                    r_serial <= (r_proc_count == GRID_W'(1));
                    if (r_proc_count == GRID_W'(1)) begin
                        r_used   <= GRID_W'(1);
                        r_status <= STAT_OK;
                        r_fatal  <= 1'b0;
                    end else begin
                        r_used   <= w_used_calc;
                        r_status <= r_odd ? STAT_ODD : STAT_OK;
                        r_fatal  <= w_fatal_calc;
                    end
                    r_state <= ST_IDLE;
                end
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Item datapath. The whole pipeline moves as one when the output
    // register is empty or its beat is being taken.
    // ------------------------------------------------------------------
    logic w_adv;
    logic w_accept;

    assign w_adv    = !o_valid || !i_stall;
    assign o_stall  = (r_state != ST_IDLE) || !w_adv;
    assign w_accept = i_valid && !o_stall;

    // Rank / n gives the x position (remainder) and the rest.
    logic              w_d1_vld;
    logic [RANK_W-1:0] w_d1_quo;
    logic [GRID_W-1:0] w_d1_rem;
    logic [RANK_W-1:0] w_d1_rank;

    gbd_div #(.DW(RANK_W), .NW(GRID_W), .SW(RANK_W)) u_div_pos1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_vld   (w_accept),
        .i_num   (i_rank),
        .i_den   (r_ndiv),
        .i_side  (i_rank),
        .o_vld   (w_d1_vld),
        .o_quo   (w_d1_quo),
        .o_rem   (w_d1_rem),
        .o_side  (w_d1_rank)
    );

    // (rank / n) / n gives the z position of a cube, the remainder its y.
    logic                  w_d2_vld;
    logic [RANK_W-1:0]     w_d2_quo;
    logic [GRID_W-1:0]     w_d2_rem;
    logic [3*RANK_W-1:0]   w_d2_side;
    logic [RANK_W-1:0]     w_rank;
    logic [RANK_W-1:0]     w_r1;
    logic [RANK_W-1:0]     w_q1;

    gbd_div #(.DW(RANK_W), .NW(GRID_W), .SW(3*RANK_W)) u_div_pos2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_vld   (w_d1_vld),
        .i_num   (w_d1_quo),
        .i_den   (r_ndiv),
        .i_side  ({w_d1_rank, w_d1_rem[RANK_W-1:0], w_d1_quo}),
        .o_vld   (w_d2_vld),
        .o_quo   (w_d2_quo),
        .o_rem   (w_d2_rem),
        .o_side  (w_d2_side)
    );

    assign {w_rank, w_r1, w_q1} = w_d2_side;

    // Axis positions and division counts; an uncut axis divides by one.
    logic [RANK_W-1:0] w_k [3];
    logic [GRID_W-1:0] w_n [3];

    always_comb begin
        w_k[0] = '0;
        w_k[1] = '0;
        w_k[2] = '0;
        w_n[0] = GRID_W'(1);
        w_n[1] = GRID_W'(1);
        w_n[2] = GRID_W'(1);
        if (!r_serial) begin
            case (r_dim_mode)
                MODE_SLAB: begin
                    w_k[0] = w_rank;
                    w_n[0] = r_ndiv;
                end
                MODE_PENCIL: begin
                    w_k[0] = w_r1;
                    w_k[1] = w_q1;
                    w_n[0] = r_ndiv;
                    w_n[1] = r_ndiv;
                end
                MODE_CUBE: begin
                    w_k[0] = w_r1;
                    w_k[1] = w_d2_rem[RANK_W-1:0];
                    w_k[2] = w_d2_quo;
                    w_n[0] = r_ndiv;
                    w_n[1] = r_ndiv;
                    w_n[2] = r_ndiv;
                end
                default: ;
            endcase
        end
    end

    // Multiply stage: k*G and (k+1)*G per axis, plus the mirror fields.
    logic               r_m_vld;
    logic [BOUND_W-1:0] r_m_lo [3];
    logic [BOUND_W-1:0] r_m_hi [3];
    logic [GRID_W-1:0]  r_m_n  [3];
    logic [RANK_W-1:0]  r_m_mirror;
    logic               r_m_upper;
    logic [GRID_W-1:0]  w_rank_ext;

    assign w_rank_ext = {1'b0, w_rank};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
        end else if (w_adv) begin
            r_m_vld <= w_d2_vld;
        end
    end

    for (genvar a = 0; a < 3; a++) begin : g_axis_mul
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_m_lo[a] <= BOUND_W'(w_k[a]) * BOUND_W'(r_grid_size);
                r_m_hi[a] <= (BOUND_W'(w_k[a]) + BOUND_W'(1)) * BOUND_W'(r_grid_size);
                r_m_n[a]  <= w_n[a];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_m_mirror <= (w_rank_ext < r_used)
                          ? RANK_W'(r_used - GRID_W'(1) - w_rank_ext) : '0;
            r_m_upper  <= !r_serial && (w_rank_ext >= {1'b0, r_used[GRID_W-1:1]});
        end
    end

    // Bound dividers: lo = k*G/n and (k+1)*G/n; the output register forms hi = (k+1)*G/n - 1.
    logic               w_b_vld;
    logic [BOUND_W-1:0] w_q_lo [3];
    logic [BOUND_W-1:0] w_q_hi [3];
    logic [RANK_W:0]    w_b_side;

    gbd_div #(.DW(BOUND_W), .NW(GRID_W), .SW(RANK_W+1)) u_div_xlo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_vld   (r_m_vld),
        .i_num   (r_m_lo[0]),
        .i_den   (r_m_n[0]),
        .i_side  ({r_m_mirror, r_m_upper}),
        .o_vld   (w_b_vld),
        .o_quo   (w_q_lo[0]),
        .o_rem   (),
        .o_side  (w_b_side)
    );

    gbd_div #(.DW(BOUND_W), .NW(GRID_W), .SW(1)) u_div_xhi (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_vld   (r_m_vld),
        .i_num   (r_m_hi[0]),
        .i_den   (r_m_n[0]),
        .i_side  (1'b0),
        .o_vld   (),
        .o_quo   (w_q_hi[0]),
        .o_rem   (),
        .o_side  ()
    );

    for (genvar a = 1; a < 3; a++) begin : g_axis_div
        gbd_div #(.DW(BOUND_W), .NW(GRID_W), .SW(1)) u_div_lo (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_vld   (r_m_vld),
            .i_num   (r_m_lo[a]),
            .i_den   (r_m_n[a]),
            .i_side  (1'b0),
            .o_vld   (),
            .o_quo   (w_q_lo[a]),
            .o_rem   (),
            .o_side  ()
        );
        gbd_div #(.DW(BOUND_W), .NW(GRID_W), .SW(1)) u_div_hi (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_vld   (r_m_vld),
            .i_num   (r_m_hi[a]),
            .i_den   (r_m_n[a]),
            .i_side  (1'b0),
            .o_vld   (),
            .o_quo   (w_q_hi[a]),
            .o_rem   (),
            .o_side  ()
        );
    end

    // Output register. A fatal setup zeroes every field but the status.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (w_adv) begin
            o_valid <= w_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            if (r_fatal) begin
                o_x_lo        <= '0;
                o_x_hi        <= '0;
                o_y_lo        <= '0;
                o_y_hi        <= '0;
                o_z_lo        <= '0;
                o_z_hi        <= '0;
                o_mirror_rank <= '0;
                o_upper_half  <= 1'b0;
                o_used_procs  <= '0;
                o_status      <= STAT_FATAL;
            end else begin
                o_x_lo        <= w_q_lo[0];
                o_x_hi        <= w_q_hi[0] - BOUND_W'(1);
                o_y_lo        <= w_q_lo[1];
                o_y_hi        <= w_q_hi[1] - BOUND_W'(1);
                o_z_lo        <= w_q_lo[2];
                o_z_hi        <= w_q_hi[2] - BOUND_W'(1);
                o_mirror_rank <= w_b_side[RANK_W:1];
                o_upper_half  <= w_b_side[0];
                o_used_procs  <= r_used;
                o_status      <= r_status;
            end
        end
    end

`ifndef SYNTHESIS
    // No rank beat may be taken while the setup pass runs.
    a_busy_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != ST_IDLE |-> o_stall)
        else $error("rank beat possible during setup pass");

    // A fatal result carries no x upper bound, no mirror rank and no processor count.
    a_fatal_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == STAT_FATAL |-> o_used_procs == '0 && o_x_hi == '0
            && o_mirror_rank == '0)
        else $error("fatal result with nonzero fields");

    // A serial job reports one processor and a clean status.
    a_serial: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && r_state == ST_IDLE && r_proc_count == GRID_W'(1)
            |-> o_used_procs == GRID_W'(1) && o_status == STAT_OK)
        else $error("serial job result is wrong");

    // An accepted beat shows up as valid in the first divider stage.
    a_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> u_div_pos1.r_vld[0])
        else $error("accepted beat lost at pipeline entry");
`endif

endmodule
